>>> src/ngb_pkg.sv
// ============================================================================
// ngb_pkg - shared types and constants for the normalised Gaussian blur
// Field widths, accumulator widths, register map and control structs.
// ============================================================================
package ngb_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 6;
    localparam int WEIGHT_W    = 10;
    localparam int NUM_WEIGHTS = 8;
    localparam int WSEL_W      = 3;
    localparam int PROD_W      = 2 * WEIGHT_W;     // weight product
    localparam int TERM_W      = PROD_W + PIX_W;   // weight * pixel
    localparam int NUM_W       = 36;               // 225 taps of TERM_W
    localparam int DEN_W       = 28;               // 225 taps of PROD_W
    localparam int QUOT_W      = 8;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 5;
    localparam int OFS_W       = 4;                // signed tap offset
    localparam int POS_W       = 8;                // signed tap position

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] t_weights;

    localparam t_weights WEIGHT_RESET = {
        10'd0, 10'd0, 10'd2, 10'd6, 10'd16, 10'd30, 10'd45, 10'd51
    };

    typedef struct packed {
        logic clr;   // clear accumulators at the start of a read
        logic vld;   // current tap lies inside the frame
    } t_mac_ctrl;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROW   = 6'b000010,
        S_TAP   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_LOAD  = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    function automatic logic [WSEL_W-1:0] f_mag(input logic signed [OFS_W-1:0] d);
        logic signed [OFS_W-1:0] neg;
        neg = -d;
        return d[OFS_W-1] ? neg[WSEL_W-1:0] : d[WSEL_W-1:0];
    endfunction

endpackage

>>> src/normalized_gaussian_blur.sv
// ============================================================================
// normalized_gaussian_blur - edge-normalised Gaussian blur over a frame store
// Stores 8-bit pixels and returns the blurred pixel at a position, the
// window clipped to the frame and normalised by the clipped weight sum.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------
//  command   start / busy               i_op, i_row, i_col, i_pixel_in
//  result    o_valid (1-cycle strobe)   o_blurred
//  config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
//  A write word never raises busy. A read word inside the frame takes
//  one weight fetch per window row, passes each tap through the shared
//  MAC, lets the pipeline drain, then runs the 8-step serial divider. A
//  read outside the frame returns 0 the next cycle. Reset is synchronous,
//  active low; weights return to their defaults and the frame store is
//  left undefined. The receiver cannot stall a result.
//
module normalized_gaussian_blur #(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64,
    parameter int MAX_RADIUS   = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [ngb_pkg::COORD_W-1:0]     i_row,
    input  logic [ngb_pkg::COORD_W-1:0]     i_col,
    input  logic [ngb_pkg::PIX_W-1:0]       i_pixel_in,
    // result
    output logic                            o_valid,
    output logic [ngb_pkg::QUOT_W-1:0]      o_blurred,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ngb_pkg::APB_AW-1:0]      paddr,
    input  logic [ngb_pkg::APB_DW-1:0]      pwdata,
    output logic [ngb_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W = 13;   // holds frame sizes up to 4096
    localparam int MUL_W = 21;   // position * width + column
    localparam logic signed [ngb_pkg::OFS_W-1:0] RAD = ngb_pkg::OFS_W'(MAX_RADIUS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ngb_pkg::t_weights                  r_weight;
    logic                               cfg_we;
    logic [ngb_pkg::WSEL_W-1:0]         cfg_idx;

    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[ngb_pkg::APB_AW-1:2];
    assign pready  = 1'b1;
    assign prdata  = ngb_pkg::APB_DW'(r_weight[cfg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= ngb_pkg::WEIGHT_RESET;
        end else if (cfg_we) begin
            r_weight[cfg_idx] <= pwdata[ngb_pkg::WEIGHT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    ngb_pkg::t_state                    r_state;
    logic [ngb_pkg::COORD_W-1:0]        r_row, r_col;
    logic signed [ngb_pkg::OFS_W-1:0]   r_dy, r_dx;
    logic [ngb_pkg::WEIGHT_W-1:0]       r_wy;
    logic                               r_drain;
    logic                               r_out_vld;
    logic [ngb_pkg::QUOT_W-1:0]         r_blurred;

    logic                               accept, in_frame, rd_go, wr_go;
    logic signed [ngb_pkg::POS_W-1:0]   tap_y, tap_x;
    logic                               tap_in;
    logic [AW-1:0]                      tap_addr, wr_addr;
    logic [ngb_pkg::WSEL_W-1:0]         wsel;
    logic [ngb_pkg::WEIGHT_W-1:0]       w_sel;
    ngb_pkg::t_mac_ctrl                 mac_ctrl;
    logic [ngb_pkg::PIX_W-1:0]          ram_rdata;
    logic [ngb_pkg::NUM_W-1:0]          acc_num;
    logic [ngb_pkg::DEN_W-1:0]          acc_den;
    logic                               div_start, div_done;
    logic [ngb_pkg::QUOT_W-1:0]         div_quot;

    assign busy     = (r_state != ngb_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign in_frame = (LIM_W'(i_row) < LIM_W'(FRAME_HEIGHT))
                   && (LIM_W'(i_col) < LIM_W'(FRAME_WIDTH));
    assign rd_go    = accept && (i_op == ngb_pkg::OP_READ);
    assign wr_go    = accept && (i_op == ngb_pkg::OP_WRITE) && in_frame;

    // current tap position, clipped against the frame
    assign tap_y  = $signed({2'b00, r_row}) + ngb_pkg::POS_W'(r_dy);
    assign tap_x  = $signed({2'b00, r_col}) + ngb_pkg::POS_W'(r_dx);
    assign tap_in = !tap_y[ngb_pkg::POS_W-1]
                 && !tap_x[ngb_pkg::POS_W-1]
                 && (LIM_W'(tap_y[ngb_pkg::POS_W-2:0]) < LIM_W'(FRAME_HEIGHT))
                 && (LIM_W'(tap_x[ngb_pkg::POS_W-2:0]) < LIM_W'(FRAME_WIDTH));

    assign tap_addr = tap_in
        ? AW'(MUL_W'(tap_y[ngb_pkg::POS_W-2:0]) * MUL_W'(FRAME_WIDTH)
              + MUL_W'(tap_x[ngb_pkg::POS_W-2:0]))
        : '0;
    assign wr_addr  = AW'(MUL_W'(i_row) * MUL_W'(FRAME_WIDTH) + MUL_W'(i_col));

    // one weight lookup a cycle: row weight in S_ROW, column weight in S_TAP
    assign wsel  = (r_state == ngb_pkg::S_ROW) ? ngb_pkg::f_mag(r_dy)
                                               : ngb_pkg::f_mag(r_dx);
    assign w_sel = r_weight[wsel];

    assign mac_ctrl.clr = rd_go;
    assign mac_ctrl.vld = (r_state == ngb_pkg::S_TAP) && tap_in;
    assign div_start    = (r_state == ngb_pkg::S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ngb_pkg::S_IDLE;
            r_out_vld <= 1'b0;
            r_drain   <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                ngb_pkg::S_IDLE: begin
                    if (rd_go) begin
                        if (in_frame) begin
                            r_state <= ngb_pkg::S_ROW;
                        end else begin
                            r_out_vld <= 1'b1;
                        end
                    end
                end
                ngb_pkg::S_ROW: begin
                    r_state <= ngb_pkg::S_TAP;
                end
                ngb_pkg::S_TAP: begin
                    if (r_dx == RAD) begin
                        if (r_dy == RAD) begin
                            r_state <= ngb_pkg::S_DRAIN;
                            r_drain <= 1'b0;
                        end else begin
                            r_state <= ngb_pkg::S_ROW;
                        end
                    end
                end
                ngb_pkg::S_DRAIN: begin
                    // wait here while the last tap runs through the MAC pipeline
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= ngb_pkg::S_LOAD;
                    end
                end
                ngb_pkg::S_LOAD: begin
                    r_state <= ngb_pkg::S_WAIT;
                end
                ngb_pkg::S_WAIT: begin
                    if (div_done) begin
                        r_state   <= ngb_pkg::S_IDLE;
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ngb_pkg::S_IDLE;
                end
            endcase
        end
    end

    // datapath registers: tap counters, row weight, result word
    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_row     <= i_row;
            r_col     <= i_col;
            r_dy      <= -RAD;
            r_blurred <= '0;
        end
        if (r_state == ngb_pkg::S_ROW) begin
            r_wy <= w_sel;
            r_dx <= -RAD;
        end
        if (r_state == ngb_pkg::S_TAP) begin
            if (r_dx == RAD) begin
                r_dy <= r_dy + ngb_pkg::OFS_W'(1);
            end else begin
                r_dx <= r_dx + ngb_pkg::OFS_W'(1);
            end
        end
        if ((r_state == ngb_pkg::S_WAIT) && div_done) begin
            r_blurred <= div_quot;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_blurred = r_blurred;

    // ------------------------------------------------------------------
    // Frame store, MAC and divider
    // ------------------------------------------------------------------
    ngb_ram #(
        .WIDTH (ngb_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (wr_go),
        .i_waddr (wr_addr),
        .i_wdata (i_pixel_in),
        .i_raddr (tap_addr),
        .o_rdata (ram_rdata)
    );

    ngb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_wy    (r_wy),
        .i_wx    (w_sel),
        .i_pixel (ram_rdata),
        .o_num   (acc_num),
        .o_den   (acc_den)
    );

    ngb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (acc_num),
        .i_den   (acc_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

>>> src/ngb_ram.sv
// ============================================================================
// ngb_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module ngb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ngb_mac.sv
// ============================================================================
// ngb_mac - shared multiply-accumulate unit
// Three stages: kernel weight product, weight * pixel, accumulate.
// ============================================================================
module ngb_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ngb_pkg::t_mac_ctrl              i_ctrl,
    input  logic [ngb_pkg::WEIGHT_W-1:0]    i_wy,
    input  logic [ngb_pkg::WEIGHT_W-1:0]    i_wx,
    input  logic [ngb_pkg::PIX_W-1:0]       i_pixel,   // arrives in the cycle after i_ctrl
    output logic [ngb_pkg::NUM_W-1:0]       o_num,
    output logic [ngb_pkg::DEN_W-1:0]       o_den
);

    logic                            r_va, r_vb;
    logic [ngb_pkg::PROD_W-1:0]      r_w, r_wb;
    logic [ngb_pkg::TERM_W-1:0]      r_term;
    logic [ngb_pkg::NUM_W-1:0]       r_num;
    logic [ngb_pkg::DEN_W-1:0]       r_den;

    always_ff @(posedge i_clk) begin
        r_w    <= ngb_pkg::PROD_W'(i_wy) * ngb_pkg::PROD_W'(i_wx);
        r_wb   <= r_w;
        r_term <= ngb_pkg::TERM_W'(r_w) * ngb_pkg::TERM_W'(i_pixel);
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_ctrl.vld;
            r_vb <= r_va;
        end
        if (i_ctrl.clr) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_vb) begin
            r_num <= r_num + ngb_pkg::NUM_W'(r_term);
            r_den <= r_den + ngb_pkg::DEN_W'(r_wb);
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

>>> src/ngb_div.sv
// ============================================================================
// ngb_div - serial restoring divider
// Eight-bit quotient, one bit a cycle; zero divisor gives zero.
// ============================================================================
module ngb_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ngb_pkg::NUM_W-1:0]       i_num,
    input  logic [ngb_pkg::DEN_W-1:0]       i_den,
    output logic                            o_done,
    output logic [ngb_pkg::QUOT_W-1:0]      o_quot
);

    logic                               r_busy, r_done, r_zero;
    logic [2:0]                         r_cnt;
    logic [ngb_pkg::NUM_W-1:0]          r_rem;
    logic [ngb_pkg::DEN_W-1:0]          r_den;
    logic [ngb_pkg::QUOT_W-1:0]         r_quot;
    logic [ngb_pkg::NUM_W-1:0]          trial;
    logic                               ge;

    // quotient is known to fit 8 bits, so start at den << 7
    assign trial = ngb_pkg::NUM_W'(r_den) << r_cnt;
    assign ge    = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_zero <= (i_den == '0);
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - trial;
            end
            r_quot <= {r_quot[ngb_pkg::QUOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for the normalised Gaussian blur
// Loads the four corner squares of the frame store, then drives directed and
// random pixel writes and blurred reads under varying kernel weights and
// sender gaps. Each blurred word is checked against an in-bench predictor of
// the clipped, normalised window sum. Register reads over APB are checked
// against the written values.
// ============================================================================
module tb_top;

    localparam int FRAME_W       = 64;
    localparam int FRAME_H       = 64;
    localparam int RADIUS        = 7;
    localparam int CORNER        = 16;    // side of each loaded corner square
    localparam int REACH         = CORNER - 1 - RADIUS;  // furthest read from an edge
    localparam int REG_STRIDE    = 4;     // byte stride of the register map
    localparam int SETTLE_CYCLES = 16;    // write words never raise busy
    localparam int TAIL_CYCLES   = 300;   // roughly one full read
    localparam int QUIET_LIMIT   = 4000;  // cycles with no traffic at all
    localparam int REPORT_MAX    = 10;
    localparam logic [ngb_pkg::WEIGHT_W-1:0] WEIGHT_MAX = '1;

    localparam ngb_pkg::t_weights DEFAULT_WEIGHTS = {
        10'd0, 10'd0, 10'd2, 10'd6, 10'd16, 10'd30, 10'd45, 10'd51
    };

    typedef enum logic [ngb_pkg::WSEL_W-1:0] {
        REG_WEIGHT_CENTER,
        REG_WEIGHT_DIST1,
        REG_WEIGHT_DIST2,
        REG_WEIGHT_DIST3,
        REG_WEIGHT_DIST4,
        REG_WEIGHT_DIST5,
        REG_WEIGHT_DIST6,
        REG_WEIGHT_DIST7
    } t_weight_reg;

    typedef enum int {
        KERNEL_RANDOM,
        KERNEL_EXTREME,
        KERNEL_DEFAULT
    } t_kernel_mode;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT-facing signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          start      = 1'b0;
    logic                          busy;
    logic                          i_op       = ngb_pkg::OP_WRITE;
    logic [ngb_pkg::COORD_W-1:0]   i_row      = '0;
    logic [ngb_pkg::COORD_W-1:0]   i_col      = '0;
    logic [ngb_pkg::PIX_W-1:0]     i_pixel_in = '0;
    logic                          o_valid;
    logic [ngb_pkg::QUOT_W-1:0]    o_blurred;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [ngb_pkg::APB_AW-1:0]    paddr      = '0;
    logic [ngb_pkg::APB_DW-1:0]    pwdata     = '0;
    logic [ngb_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    normalized_gaussian_blur #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H),
        .MAX_RADIUS   (RADIUS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_pixel_in (i_pixel_in),
        .o_valid    (o_valid),
        .o_blurred  (o_blurred),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the frame store and kernel weights
    // ------------------------------------------------------------------------
    logic [ngb_pkg::PIX_W-1:0]  frame_model [FRAME_H*FRAME_W];
    ngb_pkg::t_weights          weight_model = DEFAULT_WEIGHTS;
    logic [ngb_pkg::QUOT_W-1:0] blurred_pending [$];   // blurred words still owed

    int gap_pct      = 0;     // sender idle chance per cycle, percent
    int error_count  = 0;
    int pixel_writes = 0;
    int blur_reads   = 0;
    int blurs_seen   = 0;
    int kernel_sets  = 0;
    int quiet_cycles = 0;

    task automatic note_mismatch(input string what, input longint want, input longint got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Clipped window, weights w[|dy|]*w[|dx|], truncating divide; a zero
    // weight sum yields 0.
    function automatic logic [ngb_pkg::QUOT_W-1:0] blur_expected(input int r, input int c);
        longint unsigned num_sum;
        longint unsigned wt_sum;
        longint unsigned tap_w;
        int dist_y;
        int dist_x;
        num_sum = 0;
        wt_sum  = 0;
        for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
            if (r + dy >= 0 && r + dy < FRAME_H) begin
                dist_y = (dy < 0) ? -dy : dy;
                for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
                    if (c + dx >= 0 && c + dx < FRAME_W) begin
                        dist_x  = (dx < 0) ? -dx : dx;
                        tap_w   = 64'(weight_model[dist_y]) * 64'(weight_model[dist_x]);
                        num_sum += tap_w * 64'(frame_model[(r + dy) * FRAME_W + c + dx]);
                        wt_sum  += tap_w;
                    end
                end
            end
        end
        if (wt_sum == 0)
            return '0;
        return ngb_pkg::QUOT_W'(num_sum / wt_sum);
    endfunction

    // ------------------------------------------------------------------------
    // Command side: one word per call, start left high for a following word
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input int r, input int c, input int pix);
        int n_gap;
        n_gap = 0;
        while ($urandom_range(99) < gap_pct)
            n_gap++;
        if (n_gap > 0) begin
            start <= 1'b0;
            repeat (n_gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_row      <= ngb_pkg::COORD_W'(r);
        i_col      <= ngb_pkg::COORD_W'(c);
        i_pixel_in <= ngb_pkg::PIX_W'(pix);
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        // word taken at this edge
        if (op == ngb_pkg::OP_WRITE) begin
            frame_model[r * FRAME_W + c] = ngb_pkg::PIX_W'(pix);
            pixel_writes++;
        end else begin
            blurred_pending.push_back(blur_expected(r, c));
            blur_reads++;
        end
    endtask

    // Drop start, let every owed word come back, then allow a write word
    // still in flight to retire.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (blurred_pending.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // APB: setup, access, then idle with psel low so psel never toggles twice
    // ------------------------------------------------------------------------
    task automatic apb_write(input t_weight_reg idx,
                             input logic [ngb_pkg::WEIGHT_W-1:0] value);
        logic [ngb_pkg::APB_DW-1:0] wdata;
        wdata = $urandom();                 // upper bits are don't-care
        wdata[ngb_pkg::WEIGHT_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ngb_pkg::APB_AW'(int'(idx) * REG_STRIDE);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        weight_model[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check(input t_weight_reg idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ngb_pkg::APB_AW'(int'(idx) * REG_STRIDE);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        if (prdata[ngb_pkg::WEIGHT_W-1:0] !== weight_model[idx])
            note_mismatch($sformatf("register %s readback", idx.name()),
                          weight_model[idx], prdata[ngb_pkg::WEIGHT_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_kernel(input ngb_pkg::t_weights w);
        wait_idle();
        for (int i = 0; i < ngb_pkg::NUM_WEIGHTS; i++)
            apb_write(t_weight_reg'(i), w[i]);
        kernel_sets++;
    endtask

    function automatic ngb_pkg::t_weights pick_kernel(input t_kernel_mode mode);
        ngb_pkg::t_weights w;
        for (int i = 0; i < ngb_pkg::NUM_WEIGHTS; i++) begin
            case (mode)
                KERNEL_RANDOM:  w[i] = ngb_pkg::WEIGHT_W'($urandom_range(WEIGHT_MAX));
                KERNEL_EXTREME: w[i] = $urandom_range(1) ? WEIGHT_MAX : '0;
                default:        w[i] = DEFAULT_WEIGHTS[i];
            endcase
        end
        return w;
    endfunction

    // Stay within reach of a border, so every window sits inside a loaded
    // corner square and clipping gets plenty of exercise.
    function automatic int pick_coord(input int extent);
        case ($urandom_range(1))
            0:       return $urandom_range(REACH, 0);
            default: return $urandom_range(extent - 1, extent - 1 - REACH);
        endcase
    endfunction

    function automatic bit in_corner(input int pos, input int extent);
        return (pos < CORNER) || (pos >= extent - CORNER);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset values, both extremes and a random value on every register.
    task automatic test_register_map();
        for (int i = 0; i < ngb_pkg::NUM_WEIGHTS; i++) begin
            apb_check(t_weight_reg'(i));
            apb_write(t_weight_reg'(i), WEIGHT_MAX);
            apb_check(t_weight_reg'(i));
            apb_write(t_weight_reg'(i), '0);
            apb_check(t_weight_reg'(i));
            apb_write(t_weight_reg'(i), ngb_pkg::WEIGHT_W'($urandom_range(WEIGHT_MAX)));
            apb_check(t_weight_reg'(i));
            apb_write(t_weight_reg'(i), DEFAULT_WEIGHTS[i]);
        end
        kernel_sets++;
    endtask

    // Four corner squares written before any read; every read window lies
    // inside one of them, so no window touches unwritten data.
    task automatic test_frame_load();
        for (int r = 0; r < FRAME_H; r++)
            for (int c = 0; c < FRAME_W; c++)
                if (in_corner(r, FRAME_H) && in_corner(c, FRAME_W))
                    send_word(ngb_pkg::OP_WRITE, r, c, $urandom_range(255));
    endtask

    // Corners, borders and an unclipped window under the default kernel.
    task automatic test_edge_windows();
        send_word(ngb_pkg::OP_WRITE, 0, 0, 255);
        send_word(ngb_pkg::OP_WRITE, FRAME_H - 1, FRAME_W - 1, 0);
        send_word(ngb_pkg::OP_WRITE, 0, FRAME_W - 1, 255);
        send_word(ngb_pkg::OP_WRITE, FRAME_H - 1, 0, 0);
        send_word(ngb_pkg::OP_READ, 0, 0, 0);
        send_word(ngb_pkg::OP_READ, 0, FRAME_W - 1, 255);
        send_word(ngb_pkg::OP_READ, FRAME_H - 1, 0, 0);
        send_word(ngb_pkg::OP_READ, FRAME_H - 1, FRAME_W - 1, 255);
        send_word(ngb_pkg::OP_READ, RADIUS, RADIUS, 0);
        send_word(ngb_pkg::OP_READ, REACH, REACH, 0);
        send_word(ngb_pkg::OP_READ, 0, FRAME_W - 1 - REACH, 0);
        send_word(ngb_pkg::OP_READ, FRAME_H - 1 - RADIUS, FRAME_W - 1, 0);
    endtask

    // Centre-only, all-max, all-zero (zero weight sum) and outer-ring-only kernels.
    task automatic test_weight_extremes();
        ngb_pkg::t_weights w;
        w = '0;
        w[REG_WEIGHT_CENTER] = WEIGHT_MAX;
        load_kernel(w);
        send_word(ngb_pkg::OP_READ, REACH, REACH, 0);
        send_word(ngb_pkg::OP_READ, FRAME_H - 1, 0, 0);
        load_kernel({ngb_pkg::NUM_WEIGHTS{WEIGHT_MAX}});
        send_word(ngb_pkg::OP_READ, FRAME_H - 1, FRAME_W - 1, 0);
        send_word(ngb_pkg::OP_READ, FRAME_H - 1 - REACH, FRAME_W - 1 - REACH, 0);
        load_kernel('0);
        send_word(ngb_pkg::OP_READ, REACH, FRAME_W - 1 - REACH, 0);
        send_word(ngb_pkg::OP_READ, 0, 0, 0);
        w = '0;
        w[REG_WEIGHT_DIST7] = WEIGHT_MAX;
        load_kernel(w);
        send_word(ngb_pkg::OP_READ, 0, 0, 0);
        send_word(ngb_pkg::OP_READ, FRAME_H - 1 - REACH, 3, 0);
    endtask

    // Mixed writes and reads; halfway through the sender holds off until
    // every blurred word has come back.
    task automatic test_random_traffic(input int pct, input t_kernel_mode mode,
                                       input int n_words);
        logic op;
        int   pix;
        load_kernel(pick_kernel(mode));
        gap_pct = pct;
        for (int n = 0; n < n_words; n++) begin
            if (n == n_words / 2)
                wait_idle();
            op = ($urandom_range(99) < 40) ? ngb_pkg::OP_READ : ngb_pkg::OP_WRITE;
            case ($urandom_range(7))
                0:       pix = 0;
                1:       pix = 255;
                default: pix = $urandom_range(255);
            endcase
            send_word(op, pick_coord(FRAME_H), pick_coord(FRAME_W), pix);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and watchdog; results cannot be held off, so every
    // strobe is taken at the edge that ends it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [ngb_pkg::QUOT_W-1:0] want;
        if (i_rst_n && o_valid === 1'b1) begin
            blurs_seen++;
            if (blurred_pending.size() == 0) begin
                note_mismatch("unexpected blurred word", -1, o_blurred);
            end else begin
                want = blurred_pending.pop_front();
                if (o_blurred !== want)
                    note_mismatch("blurred", want, o_blurred);
            end
        end
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1 || psel === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, QUIET_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < FRAME_H * FRAME_W; i++)
            frame_model[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 32;
        test_register_map();
        test_frame_load();
        test_edge_windows();
        test_weight_extremes();
        test_random_traffic(32, KERNEL_RANDOM, 350);
        test_random_traffic(58, KERNEL_EXTREME, 350);
        test_random_traffic(0, KERNEL_DEFAULT, 300);

        // drain, then give the block a full read time to misbehave
        start <= 1'b0;
        while (blurred_pending.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d pixel writes and %0d blurred reads (%0d words checked)",
                 pixel_writes, blur_reads, blurs_seen);
        $display("over %0d kernel settings and three sender gap profiles; %0d errors",
                 kernel_sets, error_count);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
